[design/rc4_pkg.sv]
package rc4_pkg;

  localparam int BYTE_W     = 8;
  localparam int PERM_DEPTH = 256;

  typedef logic [BYTE_W-1:0] byte_t;

  // last index of the permutation, ends the fill and the schedule sweeps
  localparam byte_t PERM_LAST = 8'hFF;

  // input opcodes
  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_DATA = 1'b1;

endpackage

[design/rc4_ram.sv]
module rc4_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // read returns the old contents when the same entry is written in the same cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[design/rc4_stream_cipher.sv]
// RC4 stream cipher, one byte per item. Key bytes (in_opcode = 0) are taken
// without stalling and give no result; bytes past MAX_KEY_BYTES are dropped.
// The key item with in_last_in set starts the key schedule, which keeps busy
// high through the identity fill of all 256 entries and then 256 swap steps,
// each with two reads and two writes, all bound by the single RAM write port.
// A data item (in_opcode = 1) returns in_byte_in XOR the next keystream byte,
// with in_last_in copied to out_last_out. Its result shows on out_byte_out and
// out_last_out for exactly one cycle, marked by out_valid, registered after
// ST_DA, ST_DB and ST_DC; the receiver must take it then, as it cannot stall.
// A new data item may be taken in ST_DC while the last one finishes its swap;
// each makes three dependent reads and two swap writes to the permutation RAM.
// Data issued before the first complete key returns undefined bytes.
module rc4_stream_cipher #(
  parameter int MAX_KEY_BYTES = 256
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  logic          in_opcode,
  input  rc4_pkg::byte_t in_byte_in,
  input  logic          in_last_in,
  output logic          out_valid,
  output rc4_pkg::byte_t out_byte_out,
  output logic          out_last_out
);

  import rc4_pkg::*;

  localparam int KIDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int KCNT_W = $clog2(MAX_KEY_BYTES + 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,      // write the identity permutation
    ST_KS_RD_I,   // schedule: read S[n] and key[k]
    ST_KS_RD_J,   // schedule: form j, read S[j]
    ST_KS_WR_I,   // schedule: S[n] <= S[j]
    ST_KS_WR_J,   // schedule: S[j] <= old S[n]
    ST_DA,        // data: a = S[i], read S[j + a]
    ST_DB,        // data: b = S[j], S[i] <= b, read S[a + b]
    ST_DC         // data: S[j] <= a, emit result, may take the next item
  } state_t;

  state_t             state_r, state_nxt;
  byte_t              i_r, i_nxt;
  byte_t              j_r, j_nxt;
  byte_t              n_r, n_nxt;
  logic [KIDX_W-1:0]  k_r, k_nxt;
  logic [KCNT_W-1:0]  kcnt_r, kcnt_nxt;
  byte_t              sa_r, sa_nxt;
  byte_t              sb_r, sb_nxt;
  byte_t              din_r, din_nxt;
  logic               last_r, last_nxt;
  logic               fwd_r, fwd_nxt;
  logic               out_valid_r, out_valid_nxt;
  byte_t              out_byte_r, out_byte_nxt;
  logic               out_last_r, out_last_nxt;

  // permutation RAM port
  logic               p_we;
  byte_t              p_waddr, p_wdata, p_raddr, p_rdata;

  // key RAM port
  logic               k_we;
  logic [KIDX_W-1:0]  k_waddr;
  byte_t              k_rdata;

  logic               accept;
  logic               key_room;
  logic [KCNT_W-1:0]  key_len;
  logic [KCNT_W-1:0]  k_inc;
  byte_t              i_plus;
  byte_t              a_val;
  byte_t              ks_j;
  byte_t              ab_sum;
  byte_t              ks_byte;

  rc4_ram #(
    .DEPTH (PERM_DEPTH),
    .WIDTH (BYTE_W)
  ) u_perm_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  rc4_ram #(
    .DEPTH (MAX_KEY_BYTES),
    .WIDTH (BYTE_W)
  ) u_key_ram (
    .clk   (clk),
    .we    (k_we),
    .waddr (k_waddr),
    .wdata (in_byte_in),
    .raddr (k_r),
    .rdata (k_rdata)
  );

  // ST_DC only ends the swap and emits the result, so it may take a new item
  assign busy   = !(state_r == ST_IDLE || state_r == ST_DC);
  assign accept = start && !busy;

  assign key_room = kcnt_r < KCNT_W'(MAX_KEY_BYTES);
  assign key_len  = (kcnt_r == '0) ? KCNT_W'(1) : kcnt_r;
  assign k_inc    = KCNT_W'(k_r) + KCNT_W'(1);
  assign k_waddr  = kcnt_r[KIDX_W-1:0];
  assign i_plus   = i_r + 8'd1;

  // S[i] may still be in flight from the previous item's last write
  assign a_val   = fwd_r ? sa_r : p_rdata;
  assign ks_j    = j_r + k_rdata + p_rdata;
  assign ab_sum  = sa_r + sb_r;

  // S[a+b] was read before the swap landed: patch it for the swapped entries
  always_comb begin
    priority if (ab_sum == j_r) begin
      ks_byte = sa_r;
    end else if (ab_sum == i_r) begin
      ks_byte = sb_r;
    end else begin
      ks_byte = p_rdata;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    n_nxt         = n_r;
    k_nxt         = k_r;
    kcnt_nxt      = kcnt_r;
    sa_nxt        = sa_r;
    sb_nxt        = sb_r;
    din_nxt       = din_r;
    last_nxt      = last_r;
    fwd_nxt       = 1'b0;
    out_valid_nxt = 1'b0;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    p_we          = 1'b0;
    p_waddr       = n_r;
    p_wdata       = n_r;
    p_raddr       = n_r;
    k_we          = 1'b0;

    unique case (state_r)
      ST_IDLE, ST_DC: begin
        if (state_r == ST_DC) begin
          // finish the swap and emit the result
          p_we          = 1'b1;
          p_waddr       = j_r;
          p_wdata       = sa_r;
          out_valid_nxt = 1'b1;
          out_byte_nxt  = din_r ^ ks_byte;
          out_last_nxt  = last_r;
          state_nxt     = ST_IDLE;
        end
        if (accept) begin
          if (in_opcode == OP_DATA) begin
            // advance i and read S[i] at once
            i_nxt     = i_plus;
            p_raddr   = i_plus;
            din_nxt   = in_byte_in;
            last_nxt  = in_last_in;
            fwd_nxt   = (state_r == ST_DC) && (i_plus == j_r);
            state_nxt = ST_DA;
          end else begin
            // store the key byte while there is room, drop it otherwise
            if (key_room) begin
              k_we     = 1'b1;
              kcnt_nxt = kcnt_r + KCNT_W'(1);
            end
            if (in_last_in) begin
              n_nxt     = '0;
              state_nxt = ST_FILL;
            end
          end
        end
      end

      ST_FILL: begin
        p_we    = 1'b1;
        p_waddr = n_r;
        p_wdata = n_r;
        n_nxt   = n_r + 8'd1;
        if (n_r == PERM_LAST) begin
          k_nxt     = '0;
          j_nxt     = '0;
          state_nxt = ST_KS_RD_I;
        end
      end

      ST_KS_RD_I: begin
        p_raddr   = n_r;
        state_nxt = ST_KS_RD_J;
      end

      ST_KS_RD_J: begin
        j_nxt     = ks_j;
        sa_nxt    = p_rdata;
        p_raddr   = ks_j;
        state_nxt = ST_KS_WR_I;
      end

      ST_KS_WR_I: begin
        p_we      = 1'b1;
        p_waddr   = n_r;
        p_wdata   = p_rdata;
        state_nxt = ST_KS_WR_J;
      end

      ST_KS_WR_J: begin
        p_we    = 1'b1;
        p_waddr = j_r;
        p_wdata = sa_r;
        n_nxt   = n_r + 8'd1;
        // cycle through the stored key bytes
        if (k_inc >= key_len) begin
          k_nxt = '0;
        end else begin
          k_nxt = k_r + KIDX_W'(1);
        end
        if (n_r == PERM_LAST) begin
          i_nxt     = '0;
          j_nxt     = '0;
          kcnt_nxt  = '0;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_KS_RD_I;
        end
      end

      ST_DA: begin
        sa_nxt    = a_val;
        j_nxt     = j_r + a_val;
        p_raddr   = j_r + a_val;
        state_nxt = ST_DB;
      end

      ST_DB: begin
        sb_nxt    = p_rdata;
        p_we      = 1'b1;
        p_waddr   = i_r;
        p_wdata   = p_rdata;
        p_raddr   = sa_r + p_rdata;
        state_nxt = ST_DC;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      i_r         <= '0;
      j_r         <= '0;
      kcnt_r      <= '0;
      fwd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      kcnt_r      <= kcnt_nxt;
      fwd_r       <= fwd_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r        <= n_nxt;
    k_r        <= k_nxt;
    sa_r       <= sa_nxt;
    sb_r       <= sb_nxt;
    din_r      <= din_nxt;
    last_r     <= last_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_byte_out = out_byte_r;
  assign out_last_out = out_last_r;

endmodule

[design/rc4_checker.sv]
module rc4_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input logic           in_opcode,
  input logic           in_last_in,
  input logic           out_valid,
  input logic           out_last_out
);

  import rc4_pkg::*;

  logic acc_data;
  logic acc_key_mid;

  assign acc_data    = start && !busy && (in_opcode == OP_DATA);
  assign acc_key_mid = start && !busy && (in_opcode == OP_KEY) && !in_last_in;

  // reset leaves the block idle with no result pending
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_valid))
    else $error("block not idle after reset");

  // every data item yields its result
  a_data_result: assert property (@(posedge clk) disable iff (!rst_n)
    acc_data |-> ##4 out_valid)
    else $error("data item gave no result");

  // every result stems from a data item, and carries its last mark
  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(acc_data, 4) && (out_last_out == $past(in_last_in, 4))))
    else $error("result without matching data item");

  // a key byte that does not end the key leaves the block ready; a result
  // from a data item still finishing may show in that cycle
  a_key_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    acc_key_mid |=> !busy)
    else $error("plain key byte stalled the block");

endmodule

bind rc4_stream_cipher rc4_checker u_rc4_checker (.*);
